// ===== hw/rtl/prfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prfm_pkg
// Shared types, field widths and reset values for the per-port frame-rate
// meter.
// ----------------------------------------------------------------------------
package prfm_pkg;

    // default sizing
    localparam int PORTS_DEF  = 4;
    localparam int WINDOW_DEF = 100;

    // field widths
    localparam int OP_W   = 1;
    localparam int PORT_W = 3;
    localparam int TS_W   = 63;
    localparam int RATE_W = 16;
    localparam int TPS_W  = 32;

    // configuration port
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;

    localparam logic [RATE_W-1:0] RATE_CAP_RST = 16'd200;
    localparam logic [TPS_W-1:0]  TPS_RST      = 32'd1000000;

    // register index, taken from paddr[2]
    localparam logic REG_RATE_CAP = 1'b0;
    localparam logic REG_TPS      = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

endpackage
`default_nettype wire

// ===== hw/rtl/prfm_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prfm_in_if
// Request channel: record or query beats with port and timestamp.
// ----------------------------------------------------------------------------
interface prfm_in_if;
    logic                         valid;
    logic                         ready;
    logic [prfm_pkg::OP_W-1:0]    op;
    logic [prfm_pkg::PORT_W-1:0]  port;
    logic [prfm_pkg::TS_W-1:0]    timestamp;

    modport source (output valid, output op, output port, output timestamp, input ready);
    modport sink   (input valid, input op, input port, input timestamp, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/prfm_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prfm_out_if
// Result channel: frame rate and last activity time of a queried port.
// ----------------------------------------------------------------------------
interface prfm_out_if;
    logic                         valid;
    logic                         ready;
    logic [prfm_pkg::RATE_W-1:0]  frame_rate;
    logic [prfm_pkg::TS_W-1:0]    last_arrival;

    modport source (output valid, output frame_rate, output last_arrival, input ready);
    modport sink   (input valid, input frame_rate, input last_arrival, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/prfm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prfm_div
// Restoring radix-2 divider, one quotient bit per cycle. Done pulses in the
// cycle after the last step, with the quotient held in o_quo.
// ----------------------------------------------------------------------------
module prfm_div #(
    parameter int NW = 40,
    parameter int DW = prfm_pkg::TS_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int SW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_step;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_q;

    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    assign rem_sh  = {r_rem, r_q[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == SW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + SW'(1);
            end
        end
    end

    // dividend shifts out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
`default_nettype wire

// ===== hw/rtl/per_port_frame_rate_meter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_port_frame_rate_meter
// Sliding-window frame-rate meter with one timestamp ring per port.
// Record beat: written straight into the stamp RAM; the next beat
//   may follow in the next cycle.
// Query beat: reads the oldest and newest stamps, then runs the bit-serial
//   divider, NW = clog2(WINDOW+1) + 32 bits wide (39 at WINDOW = 100); a
//   bad port, fewer than two samples or a non-positive span skip it. No
//   new beat is taken until the result is loaded; a stalled result holds it off.
// Reset: pointers, counts, last-seen times clear, registers take reset values;
//   the stamp RAM is not cleared, only written entries are read.
// ----------------------------------------------------------------------------
module per_port_frame_rate_meter #(
    parameter int PORTS  = prfm_pkg::PORTS_DEF,
    parameter int WINDOW = prfm_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    prfm_in_if.sink                       i_in,
    prfm_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prfm_pkg::PADDR_W-1:0]  paddr,
    input  logic [prfm_pkg::APB_DW-1:0]   pwdata,
    output logic [prfm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int IW    = $clog2(WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int PW    = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int AW    = PW + IW;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = CW + prfm_pkg::TPS_W;
    localparam int TW    = prfm_pkg::TS_W;
    localparam int RW    = prfm_pkg::RATE_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RDNEW = 5'b00010,
        S_SPAN  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [RW-1:0]              r_rate_cap;
    logic [prfm_pkg::TPS_W-1:0] r_tps;

    // per-port state
    logic [IW-1:0] r_wp   [PORTS];
    logic [CW-1:0] r_cnt  [PORTS];
    logic [TW-1:0] r_last [PORTS];

    // stamp RAM
    logic [TW-1:0] r_mem [DEPTH];
    logic [TW-1:0] r_rdata;

    // query context
    logic [PW-1:0] r_pidx;
    logic [IW-1:0] r_new_i;
    logic [CW-1:0] r_cnt_q;
    logic [TW-1:0] r_oldest;
    logic [TW-1:0] r_last_q;
    logic          r_zero;
    logic [RW-1:0] r_rate;

    // output stage
    logic          r_out_valid;
    logic [RW-1:0] r_out_rate;
    logic [TW-1:0] r_out_last;

    logic          in_acc;
    logic          is_query;
    logic          port_ok;
    logic [PW-1:0] in_pidx;
    logic [IW-1:0] cur_wp;
    logic [CW-1:0] cur_cnt;
    logic [CW-1:0] wp_ext;
    logic [CW-1:0] old_c;
    logic [IW-1:0] old_i;
    logic [IW-1:0] new_i;
    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic          out_load;
    logic          span_pos;
    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [NW-1:0] div_num;
    logic [TW-1:0] div_den;
    logic [CW-1:0] cnt_m1;
    logic          cfg_we;

    assign in_acc   = i_in.valid && i_in.ready;
    assign is_query = i_in.op == prfm_pkg::OP_QUERY;
    assign port_ok  = {1'b0, i_in.port} < 4'(PORTS);
    assign in_pidx  = i_in.port[PW-1:0];
    assign cur_wp   = r_wp[in_pidx];
    assign cur_cnt  = r_cnt[in_pidx];

    // oldest = (wp - cnt) mod WINDOW; the wrapped result fits CW bits
    assign wp_ext = CW'(cur_wp);
    assign old_c  = (wp_ext >= cur_cnt) ? (wp_ext - cur_cnt)
                                        : (wp_ext + CW'(WINDOW) - cur_cnt);
    assign old_i  = old_c[IW-1:0];
    assign new_i  = (cur_wp == '0) ? IW'(WINDOW - 1) : (cur_wp - IW'(1));

    assign mem_we  = in_acc && !is_query && port_ok;
    assign rd_addr = (r_state == S_IDLE) ? {in_pidx, old_i} : {r_pidx, r_new_i};

    assign i_in.ready = r_state == S_IDLE;

    // ------------------------------------------------------------------ RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[{in_pidx, cur_wp}] <= i_in.timestamp;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // ------------------------------------------------------ per-port state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++) begin
                r_wp[p]   <= '0;
                r_cnt[p]  <= '0;
                r_last[p] <= '0;
            end
        end else if (mem_we) begin
            r_wp[in_pidx]   <= (cur_wp == IW'(WINDOW - 1)) ? '0 : cur_wp + IW'(1);
            r_last[in_pidx] <= i_in.timestamp;
            if (cur_cnt < CW'(WINDOW)) begin
                r_cnt[in_pidx] <= cur_cnt + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------ sequencer
    assign span_pos  = r_rdata > r_oldest;
    assign div_start = (r_state == S_SPAN) && span_pos;
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = (port_ok && cur_cnt >= CW'(2)) ? S_RDNEW : S_OUT;
                end
            end
            S_RDNEW: n_state = S_SPAN;
            S_SPAN:  n_state = span_pos ? S_DIV : S_OUT;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pidx   <= in_pidx;
                r_new_i  <= new_i;
                r_cnt_q  <= cur_cnt;
                r_last_q <= port_ok ? r_last[in_pidx] : '0;
                r_zero   <= !(port_ok && cur_cnt >= CW'(2));
            end
            S_RDNEW: r_oldest <= r_rdata;
            S_SPAN: begin
                if (!span_pos) begin
                    r_zero <= 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_rate <= (div_quo > NW'(r_rate_cap)) ? r_rate_cap : div_quo[RW-1:0];
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------- divider
    assign cnt_m1  = r_cnt_q - CW'(1);
    assign div_num = NW'(cnt_m1) * NW'(r_tps);
    assign div_den = r_rdata - r_oldest;

    prfm_div #(
        .NW (NW),
        .DW (TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // --------------------------------------------------------- output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rate <= r_zero ? '0 : r_rate;
            r_out_last <= r_last_q;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_rate   = r_out_rate;
    assign o_out.last_arrival = r_out_last;

    // ------------------------------------------------------------ registers
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_cap <= prfm_pkg::RATE_CAP_RST;
            r_tps      <= prfm_pkg::TPS_RST;
        end else if (cfg_we) begin
            if (paddr[2] == prfm_pkg::REG_RATE_CAP) begin
                r_rate_cap <= pwdata[RW-1:0];
            end else begin
                r_tps <= pwdata[prfm_pkg::TPS_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == prfm_pkg::REG_TPS) ? r_tps
                                                    : {{(prfm_pkg::APB_DW - RW){1'b0}},
                                                       r_rate_cap};

endmodule
`default_nettype wire

// ===== hw/rtl/prfm_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prfm_chk
// Port-level checks for the frame-rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module prfm_chk (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          i_in_ready,
    input wire [prfm_pkg::OP_W-1:0]     i_in_op,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [prfm_pkg::RATE_W-1:0]   i_out_rate,
    input wire [prfm_pkg::TS_W-1:0]     i_out_last
);

    logic in_beat;
    assign in_beat = i_in_valid && i_in_ready;

    // output stage comes out of reset empty
    a_out_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_rate) && $stable(i_out_last))
        else $error("stalled result beat changed");

    // a query occupies the block
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_in_op == prfm_pkg::OP_QUERY |=> !i_in_ready)
        else $error("request accepted during query");

    // a record finishes in its own cycle
    a_record_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_in_op == prfm_pkg::OP_RECORD |=> i_in_ready)
        else $error("record beat stalled the request channel");

    // a new result only appears at the end of query work
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a query in flight");

endmodule

bind per_port_frame_rate_meter prfm_chk u_prfm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_rate  (o_out.frame_rate),
    .i_out_last  (o_out.last_arrival)
);
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the per-port frame-rate meter against a predictor of its own. Record
// and query beats go in with bursty pacing, and the result side stalls in
// patterns. Every result is checked against the oldest pending prediction.
// The rate limit and tick registers are rewritten between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import prfm_pkg::*;

    localparam int PORTS  = PORTS_DEF;
    localparam int WINDOW = WINDOW_DEF;
    localparam int SETTLE = 60;   // cycles past the last result before a register write

    typedef struct packed {
        logic [RATE_W-1:0] frame_rate;
        logic [TS_W-1:0]   last_arrival;
    } t_meter_reading;

    typedef enum int {STEP_FINE, STEP_MID, STEP_COARSE, STEP_WILD} t_step_kind;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} t_rx_pattern;

    class frame_rate_tracker;
        logic [TS_W-1:0]   ring [PORTS][WINDOW];
        int unsigned       wr_ptr [PORTS];
        int unsigned       fill [PORTS];
        logic [TS_W-1:0]   seen [PORTS];
        logic [RATE_W-1:0] cap;
        logic [TPS_W-1:0]  tps;
        t_meter_reading    readings_due [$];
        int                errors;
        int                n_records;
        int                n_ignored;
        int                n_queries;

        function new();
            for (int p = 0; p < PORTS; p++) begin
                wr_ptr[p] = 0;
                fill[p]   = 0;
                seen[p]   = '0;
            end
            cap = RATE_CAP_RST;
            tps = TPS_RST;
            errors = 0;
            n_records = 0;
            n_ignored = 0;
            n_queries = 0;
        endfunction

        function void set_reg(logic idx, logic [APB_DW-1:0] value);
            if (idx == REG_RATE_CAP) begin
                cap = value[RATE_W-1:0];
            end else begin
                tps = value[TPS_W-1:0];
            end
        endfunction

        function logic [RATE_W-1:0] predict_rate(int p);
            int unsigned       oldest_i;
            int unsigned       newest_i;
            longint unsigned   span;
            longint unsigned   num;
            longint unsigned   q;
            if (fill[p] < 2) return '0;
            oldest_i = (wr_ptr[p] + WINDOW - fill[p]) % WINDOW;
            newest_i = (wr_ptr[p] + WINDOW - 1) % WINDOW;
            if (ring[p][newest_i] <= ring[p][oldest_i]) return '0;
            span = {1'b0, ring[p][newest_i]} - {1'b0, ring[p][oldest_i]};
            num  = longint'(fill[p] - 1) * longint'({32'd0, tps});
            q    = num / span;
            if (q > {48'd0, cap}) return cap;
            return q[RATE_W-1:0];
        endfunction

        function void note_beat(t_op op, logic [PORT_W-1:0] port, logic [TS_W-1:0] ts);
            t_meter_reading r;
            int p;
            p = int'(port);
            if (op == OP_RECORD) begin
                if (p >= PORTS) begin
                    n_ignored++;
                    return;
                end
                n_records++;
                ring[p][wr_ptr[p]] = ts;
                wr_ptr[p] = (wr_ptr[p] + 1 >= WINDOW) ? 0 : wr_ptr[p] + 1;
                if (fill[p] < WINDOW) fill[p]++;
                seen[p] = ts;
                return;
            end
            n_queries++;
            if (p >= PORTS) begin
                r = '0;
            end else begin
                r.frame_rate   = predict_rate(p);
                r.last_arrival = seen[p];
            end
            readings_due.push_back(r);
        endfunction

        function void check_reading(logic [RATE_W-1:0] rate, logic [TS_W-1:0] last);
            t_meter_reading x;
            if (readings_due.size() == 0) begin
                $error("unexpected result: frame_rate %0d, last_arrival %0d", rate, last);
                errors++;
                return;
            end
            x = readings_due.pop_front();
            if (rate !== x.frame_rate) begin
                $error("frame_rate mismatch: expected %0d, actual %0d", x.frame_rate, rate);
                errors++;
            end
            if (last !== x.last_arrival) begin
                $error("last_arrival mismatch: expected %0d, actual %0d",
                       x.last_arrival, last);
                errors++;
            end
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                rx_ready = 1'b0;

    prfm_in_if  in_if ();
    prfm_out_if out_if ();

    assign out_if.ready = rx_ready;

    frame_rate_tracker tracker = new();

    per_port_frame_rate_meter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check, then pick the next ready value
    int          rx_cycle = 0;
    t_rx_pattern rx_mode  = RX_OPEN;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            tracker.check_reading(out_if.frame_rate, out_if.last_arrival);
        end
        rx_cycle = (rx_cycle + 1) % 48;
        if (rx_cycle == 0) rx_mode = t_rx_pattern'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   rx_ready <= 1'b1;
            RX_COIN:   rx_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rx_ready <= (rx_cycle % 4 == 0);
            default:   rx_ready <= (rx_cycle >= 30);
        endcase
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    int burst_left = 0;
    int n_settings = 0;

    function automatic logic [TS_W-1:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TS_W-1:0];
    endfunction

    task automatic send_beat(input t_op op, input int port, input logic [TS_W-1:0] ts);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.port      <= PORT_W'(port);
        in_if.timestamp <= ts;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        tracker.note_beat(op, PORT_W'(port), ts);
    endtask

    // hold the sender until every pending result is back, then let the block settle
    task automatic drain();
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [APB_DW-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        tracker.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    initial begin
        logic [RATE_W-1:0] cap_set [6];
        logic [TPS_W-1:0]  tps_set [6];
        logic [TS_W-1:0]   now_ts [PORTS];
        t_step_kind        step_kind [PORTS];
        logic [TS_W-1:0]   ts;
        logic [TS_W-1:0]   step;
        int                p;
        int                r;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_RECORD;
        in_if.port      <= '0;
        in_if.timestamp <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: empty ports, invalid ports, degenerate spans, extremes
        send_beat(OP_QUERY,  0, '0);
        send_beat(OP_QUERY,  7, '1);
        send_beat(OP_RECORD, 5, '1);          // invalid port, ignored
        send_beat(OP_QUERY,  5, '0);
        send_beat(OP_RECORD, 0, 63'd1000);
        send_beat(OP_QUERY,  0, '0);          // single sample
        send_beat(OP_RECORD, 0, 63'd1000);
        send_beat(OP_QUERY,  0, '0);          // zero span
        send_beat(OP_RECORD, 1, 63'd5000);
        send_beat(OP_RECORD, 1, 63'd3000);
        send_beat(OP_QUERY,  1, '0);          // newest before oldest
        send_beat(OP_RECORD, 2, 63'd0);
        send_beat(OP_RECORD, 2, 63'd5000);
        send_beat(OP_QUERY,  2, '0);          // rate lands exactly on the limit
        send_beat(OP_RECORD, 2, 63'd5001);
        send_beat(OP_QUERY,  2, '0);          // saturates
        send_beat(OP_RECORD, 3, '1);
        send_beat(OP_QUERY,  3, '0);
        send_beat(OP_RECORD, 3, '0);
        send_beat(OP_QUERY,  3, '1);
        reg_write(REG_TPS, 32'd0);            // zero numerator
        send_beat(OP_QUERY,  2, '0);
        reg_write(REG_RATE_CAP, 32'hFFFF);
        reg_write(REG_TPS, 32'hFFFF_FFFF);
        send_beat(OP_QUERY,  2, '0);
        reg_write(REG_RATE_CAP, 32'd500);
        reg_write(REG_TPS, 32'd1000000);
        send_beat(OP_QUERY,  2, '0);
        send_beat(OP_QUERY,  4, '0);

        cap_set = '{16'd200, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1000};
        tps_set = '{32'd1000000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1, 32'd1000000};
        cap_set[3] = 16'($urandom);
        tps_set[3] = $urandom;
        for (int i = 0; i < PORTS; i++) now_ts[i] = rand_stamp();

        for (int phase = 0; phase < 6; phase++) begin
            reg_write(REG_RATE_CAP, {16'd0, cap_set[phase]});
            reg_write(REG_TPS, tps_set[phase]);
            for (int i = 0; i < PORTS; i++) step_kind[i] = t_step_kind'($urandom_range(0, 3));
            for (int k = 0; k < 142; k++) begin
                r = $urandom_range(0, 99);
                p = $urandom_range(0, PORTS - 1);
                if (r < 62) begin
                    case (step_kind[p])
                        STEP_FINE:   step = TS_W'($urandom_range(1, 64));
                        STEP_MID:    step = TS_W'($urandom_range(1000, 20000));
                        STEP_COARSE: step = TS_W'($urandom_range(100000, 10000000));
                        default:     step = TS_W'($urandom);
                    endcase
                    now_ts[p] = now_ts[p] + step;
                    send_beat(OP_RECORD, p, now_ts[p]);
                end else if (r < 86) begin
                    send_beat(OP_QUERY, p, rand_stamp());
                end else if (r < 90) begin
                    send_beat(OP_QUERY, $urandom_range(PORTS, 7), rand_stamp());
                end else if (r < 94) begin
                    send_beat(OP_RECORD, $urandom_range(PORTS, 7), rand_stamp());
                end else if (r < 97) begin
                    // jump to an arbitrary stamp and carry on from there
                    now_ts[p] = rand_stamp();
                    send_beat(OP_RECORD, p, now_ts[p]);
                end else begin
                    // out-of-order arrival
                    ts = now_ts[p] - TS_W'($urandom_range(0, 5000));
                    send_beat(OP_RECORD, p, ts);
                end
            end
        end

        drain();
        $display("Covered %0d records, %0d ignored records, %0d queries",
                 tracker.n_records, tracker.n_ignored, tracker.n_queries);
        $display("across %0d register writes with window wrap on all ports", n_settings);
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/prfm_pkg.sv
hw/rtl/prfm_in_if.sv
hw/rtl/prfm_out_if.sv
hw/rtl/prfm_div.sv
hw/rtl/per_port_frame_rate_meter.sv
hw/rtl/prfm_chk.sv
test/testbench.sv
